### rtl/core/eops_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eops_pkg
// shared widths and the sort key mapping for the even/odd partition sorter
// ----------------------------------------------------------------------------
package eops_pkg;

    localparam int DATA_W           = 32;
    localparam int KEY_W            = DATA_W + 1;
    localparam int DEFAULT_CAPACITY = 64;

    // one ascending order over the key gives evens ascending, then odds descending
    function automatic logic [KEY_W-1:0] sort_key(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] biased;
        biased = v ^ {1'b1, {(DATA_W-1){1'b0}}};
        if (v[0])
        begin
            return {1'b1, ~biased};
        end
        return {1'b0, biased};
    endfunction

endpackage
`default_nettype wire

### rtl/core/eops_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eops_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module eops_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/core/eops_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eops_select
// shared compare unit: keeps the smallest (key, index) above the last one sent
// ----------------------------------------------------------------------------
module eops_select #(
    parameter int IDX_W = 6
) (
    input  wire logic [eops_pkg::KEY_W-1:0] cand_key,
    input  wire logic [IDX_W-1:0]           cand_idx,
    input  wire logic                       prev_valid,
    input  wire logic [eops_pkg::KEY_W-1:0] prev_key,
    input  wire logic [IDX_W-1:0]           prev_idx,
    input  wire logic                       best_valid,
    input  wire logic [eops_pkg::KEY_W-1:0] best_key,
    input  wire logic [IDX_W-1:0]           best_idx,
    output logic                            take
);
    import eops_pkg::*;

    logic above_prev;
    logic below_best;

    // index breaks ties so equal values each go out exactly once
    assign above_prev = !prev_valid || ({cand_key, cand_idx} > {prev_key, prev_idx});
    assign below_best = !best_valid || ({cand_key, cand_idx} < {best_key, best_idx});
    assign take       = above_prev && below_best;

endmodule
`default_nettype wire

### rtl/core/even_odd_partition_sorter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// even_odd_partition_sorter
// collects a set of signed values and returns evens ascending, then odds descending
// ----------------------------------------------------------------------------
// Values arrive one request per cycle while item_stall is low and are written
// into a CAPACITY-entry ram; requests beyond capacity are dropped and flag
// overflow on every result of that set. The request with last_in high closes
// the set, and item_stall stays high until the final result has been taken.
// Each result is found by one scan of the ram through a single shared compare
// unit, looking for the smallest sort key above the one sent before (ties
// broken by ram index), so each result takes a full scan: the ram reads, the
// registered read data reaching the compare unit, then a hold in the emit
// state until the result is taken. The ram read port and the compare unit set
// the pace. The sort key puts evens first by signed value, then odds by
// inverted signed value, so one ascending order covers both halves.
// ----------------------------------------------------------------------------
module even_odd_partition_sorter #(
    parameter int CAPACITY = eops_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input requests
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire logic [eops_pkg::DATA_W-1:0] value,
    input  wire logic                        last_in,
    // results
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic      [eops_pkg::DATA_W-1:0] sorted_value,
    output logic                             last_out,
    output logic                             overflow
);
    import eops_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // control state
    state_t             state_reg,      state_next;
    logic [CNT_W-1:0]   count_reg,      count_next;
    logic               ovf_reg,        ovf_next;
    logic [CNT_W-1:0]   scan_addr_reg,  scan_addr_next;
    logic               rd_valid_reg,   rd_valid_next;
    logic [IDX_W-1:0]   rd_idx_reg,     rd_idx_next;
    logic               best_valid_reg, best_valid_next;
    logic               prev_valid_reg, prev_valid_next;
    logic [IDX_W-1:0]   emit_cnt_reg,   emit_cnt_next;

    // payload
    logic [KEY_W-1:0]   best_key_reg,   best_key_next;
    logic [IDX_W-1:0]   best_idx_reg,   best_idx_next;
    logic [DATA_W-1:0]  best_val_reg,   best_val_next;
    logic [KEY_W-1:0]   prev_key_reg,   prev_key_next;
    logic [IDX_W-1:0]   prev_idx_reg,   prev_idx_next;

    logic               item_acc;
    logic               result_acc;
    logic               store_full;
    logic               wr_en;
    logic               rd_en;
    logic [DATA_W-1:0]  rd_data;
    logic [KEY_W-1:0]   cand_key;
    logic               take;
    logic [CNT_W-1:0]   count_m1;
    logic               scan_done;

    assign item_stall   = (state_reg != ST_LOAD);
    assign item_acc     = item_valid && !item_stall;
    assign result_valid = (state_reg == ST_EMIT);
    assign result_acc   = result_valid && !result_stall;

    assign store_full   = (count_reg == CNT_W'(CAPACITY));
    assign wr_en        = item_acc && !store_full;

    // one ram read per scan cycle, while addresses remain below the count
    assign rd_en        = (state_reg == ST_SCAN) && (scan_addr_reg < count_reg);
    assign count_m1     = count_reg - CNT_W'(1);
    assign scan_done    = rd_valid_reg && (rd_idx_reg == count_m1[IDX_W-1:0]);

    assign cand_key     = sort_key(rd_data);

    assign sorted_value = best_val_reg;
    assign last_out     = (emit_cnt_reg == count_m1[IDX_W-1:0]);
    assign overflow     = ovf_reg;

    eops_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (scan_addr_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    eops_select #(
        .IDX_W (IDX_W)
    ) u_select (
        .cand_key   (cand_key),
        .cand_idx   (rd_idx_reg),
        .prev_valid (prev_valid_reg),
        .prev_key   (prev_key_reg),
        .prev_idx   (prev_idx_reg),
        .best_valid (best_valid_reg),
        .best_key   (best_key_reg),
        .best_idx   (best_idx_reg),
        .take       (take)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        scan_addr_next  = scan_addr_reg;
        rd_valid_next   = rd_en;
        rd_idx_next     = scan_addr_reg[IDX_W-1:0];
        best_valid_next = best_valid_reg;
        prev_valid_next = prev_valid_reg;
        emit_cnt_next   = emit_cnt_reg;
        best_key_next   = best_key_reg;
        best_idx_next   = best_idx_reg;
        best_val_next   = best_val_reg;
        prev_key_next   = prev_key_reg;
        prev_idx_next   = prev_idx_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (item_acc)
                begin
                    if (store_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_in)
                    begin
                        // first scan of the set has no lower bound
                        state_next      = ST_SCAN;
                        scan_addr_next  = '0;
                        best_valid_next = 1'b0;
                        prev_valid_next = 1'b0;
                        emit_cnt_next   = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end
                if (rd_valid_reg && take)
                begin
                    best_valid_next = 1'b1;
                    best_key_next   = cand_key;
                    best_idx_next   = rd_idx_reg;
                    best_val_next   = rd_data;
                end
                if (scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (result_acc)
                begin
                    if (last_out)
                    begin
                        // set done, ready for the next one
                        state_next = ST_LOAD;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        state_next      = ST_SCAN;
                        scan_addr_next  = '0;
                        best_valid_next = 1'b0;
                        prev_valid_next = 1'b1;
                        prev_key_next   = best_key_reg;
                        prev_idx_next   = best_idx_reg;
                        emit_cnt_next   = emit_cnt_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            scan_addr_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            rd_idx_reg     <= '0;
            best_valid_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
            emit_cnt_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            scan_addr_reg  <= scan_addr_next;
            rd_valid_reg   <= rd_valid_next;
            rd_idx_reg     <= rd_idx_next;
            best_valid_reg <= best_valid_next;
            prev_valid_reg <= prev_valid_next;
            emit_cnt_reg   <= emit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_key_reg <= best_key_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        prev_key_reg <= prev_key_next;
        prev_idx_reg <= prev_idx_next;
    end

endmodule
`default_nettype wire
